[hw/rtl/tsd_pkg.sv]
package tsd_pkg;

  localparam int unsigned BLOCK_BYTES = 512;
  localparam int unsigned SIZE_DIGITS = 12;
  localparam int unsigned OFF_W       = $clog2(BLOCK_BYTES);
  localparam int unsigned SIZE_W      = 36;

  localparam logic [OFF_W-1:0] SIZE_FIRST = OFF_W'(124);
  localparam logic [OFF_W-1:0] SIZE_LAST  = OFF_W'(124 + SIZE_DIGITS - 1);
  localparam logic [OFF_W-1:0] TYPE_POS   = OFF_W'(156);
  localparam logic [OFF_W-1:0] BLOCK_END  = OFF_W'(BLOCK_BYTES - 1);

  localparam logic [7:0] CHAR_BLANK = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_ONE   = 8'h31;

  typedef enum logic [1:0] {
    KIND_PAYLOAD    = 2'd0,
    KIND_FILE_START = 2'd1,
    KIND_LINK_UNSUP = 2'd2,
    KIND_END        = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         data_byte;
    logic [SIZE_W-1:0]  file_size;
    logic               last_byte;
  } result_t;

  typedef struct packed {
    logic full;
    logic valid;
  } queue_status_t;

endpackage

[hw/rtl/tsd_if.sv]
interface tsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] archive_byte;

  modport source (output valid, output archive_byte, input ready);
  modport sink (input valid, input archive_byte, output ready);
endinterface

interface tsd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [35:0] file_size;
  logic        last_byte;

  modport source (output valid, output kind, output data_byte, output file_size,
                  output last_byte, input ready);
  modport sink (input valid, input kind, input data_byte, input file_size,
                input last_byte, output ready);
endinterface

[hw/rtl/tsd_front.sv]
module tsd_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            byte_i,
  output logic                  push_o,
  output tsd_pkg::result_t      result_o
);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_DONE   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    PM_BLANKS  = 2'd0,
    PM_DIGITS  = 2'd1,
    PM_STOPPED = 2'd2
  } parse_e;

  phase_e                          phase_q, phase_d;
  parse_e                          mode_q, mode_d, mode_v;
  logic [tsd_pkg::OFF_W-1:0]       offset_q, offset_d;
  logic [tsd_pkg::SIZE_W-1:0]      accum_q, accum_d, accum_v;
  logic [tsd_pkg::SIZE_W-1:0]      remain_q, remain_d, remain_dec;
  logic [7:0]                      etype_q, etype_d, etype_v;
  logic                            empty_q, empty_d, empty_v;
  logic                            regular_q, regular_d, regular_v;
  logic                            at_end, in_window, is_digit, is_blank;

  assign at_end     = (offset_q == tsd_pkg::BLOCK_END);
  assign in_window  = (offset_q >= tsd_pkg::SIZE_FIRST) && (offset_q <= tsd_pkg::SIZE_LAST);
  assign is_digit   = (byte_i[7:3] == tsd_pkg::CHAR_ZERO[7:3]);
  assign is_blank   = (byte_i == tsd_pkg::CHAR_BLANK) || (byte_i == tsd_pkg::CHAR_TAB);
  assign remain_dec = remain_q - tsd_pkg::SIZE_W'(1);

  always_comb begin
    phase_d   = phase_q;
    mode_d    = mode_q;
    offset_d  = offset_q;
    accum_d   = accum_q;
    remain_d  = remain_q;
    etype_d   = etype_q;
    empty_d   = empty_q;
    regular_d = regular_q;
    push_o    = 1'b0;
    result_o  = '0;

    // Header fields restart at the first byte of every header block.
    if (offset_q == '0) begin
      accum_v = '0;
      mode_v  = PM_BLANKS;
      etype_v = 8'h00;
      empty_v = (byte_i == 8'h00);
    end else begin
      accum_v = accum_q;
      mode_v  = mode_q;
      etype_v = etype_q;
      empty_v = empty_q;
    end
    regular_v = (etype_v == tsd_pkg::CHAR_ZERO) || (etype_v == 8'h00);

    if (accept_i) begin
      case (phase_q)
        PH_HEADER: begin
          accum_d  = accum_v;
          mode_d   = mode_v;
          etype_d  = etype_v;
          empty_d  = empty_v;
          offset_d = offset_q + tsd_pkg::OFF_W'(1);
          if (in_window && !(mode_v == PM_BLANKS && is_blank) && mode_v != PM_STOPPED) begin
            if (is_digit) begin
              accum_d = {accum_v[tsd_pkg::SIZE_W-4:0], byte_i[2:0]};
              mode_d  = PM_DIGITS;
            end else begin
              mode_d = PM_STOPPED;
            end
          end
          if (offset_q == tsd_pkg::TYPE_POS) begin
            etype_d = byte_i;
          end
          if (at_end) begin
            if (empty_v) begin
              push_o        = 1'b1;
              result_o.kind = tsd_pkg::KIND_END;
              phase_d       = PH_DONE;
            end else if (etype_v == tsd_pkg::CHAR_ONE) begin
              push_o        = 1'b1;
              result_o.kind = tsd_pkg::KIND_LINK_UNSUP;
            end else begin
              regular_d = regular_v;
              remain_d  = accum_v;
              if (regular_v) begin
                push_o             = 1'b1;
                result_o.kind      = tsd_pkg::KIND_FILE_START;
                result_o.file_size = accum_v;
              end
              if (accum_v != '0) begin
                phase_d = PH_BODY;
              end
            end
          end
        end
        PH_BODY: begin
          offset_d = offset_q + tsd_pkg::OFF_W'(1);
          if (remain_q != '0) begin
            remain_d = remain_dec;
            if (regular_q) begin
              push_o             = 1'b1;
              result_o.kind      = tsd_pkg::KIND_PAYLOAD;
              result_o.data_byte = byte_i;
              result_o.last_byte = (remain_dec == '0);
            end
          end
          // Padding after the last body byte is dropped up to the block end.
          if (at_end && remain_d == '0) begin
            phase_d = PH_HEADER;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      mode_q    <= PM_BLANKS;
      offset_q  <= '0;
      accum_q   <= '0;
      remain_q  <= '0;
      etype_q   <= 8'h00;
      empty_q   <= 1'b0;
      regular_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      mode_q    <= mode_d;
      offset_q  <= offset_d;
      accum_q   <= accum_d;
      remain_q  <= remain_d;
      etype_q   <= etype_d;
      empty_q   <= empty_d;
      regular_q <= regular_d;
    end
  end

endmodule

[hw/rtl/tsd_queue.sv]
module tsd_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  tsd_pkg::result_t        push_data_i,
  input  logic                    pop_i,
  output tsd_pkg::result_t        head_o,
  output tsd_pkg::queue_status_t  status_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  tsd_pkg::result_t  entries_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_push, do_pop;

  assign status_o.full  = (count_q == CntW'(Depth));
  assign status_o.valid = (count_q != '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && status_o.valid;
  assign head_o         = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

[hw/rtl/tsd_back.sv]
module tsd_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tsd_pkg::queue_status_t  status_i,
  input  tsd_pkg::result_t        head_i,
  output logic                    pop_o,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output tsd_pkg::result_t        out_data_o
);

  logic              valid_q;
  tsd_pkg::result_t  data_q;

  // Refill the output register whenever it is empty or its beat is taken.
  assign pop_o       = status_i.valid && (!valid_q || out_ready_i);
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

endmodule

[hw/rtl/tar_stream_deframer.sv]
// Channel | Dir | Beat payload                               | Accepted when
// in_i    | in  | archive_byte                               | valid && ready
// out_o   | out | kind, data_byte, file_size, last_byte      | valid && ready
//
// Archive bytes are taken on valid && ready; a result is written to the queue at
// the accepting edge and reaches out_o through the output register.
// A new byte can be accepted every cycle while the result queue has room, so
// sustained rate is one byte per cycle; stalls on out_o back up through the
// QUEUE_DEPTH entry queue before in_i.ready drops.
// Reset is asynchronous and active low; no clearing pass is needed.
module tar_stream_deframer #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tsd_in_if.sink       in_i,
  tsd_out_if.source    out_o
);

  logic                    accept;
  logic                    push;
  logic                    pop;
  tsd_pkg::result_t        push_data;
  tsd_pkg::result_t        head;
  tsd_pkg::result_t        out_data;
  tsd_pkg::queue_status_t  status;
  logic                    out_valid;

  assign in_i.ready = !status.full;
  assign accept     = in_i.valid && in_i.ready;

  tsd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (in_i.archive_byte),
    .push_o   (push),
    .result_o (push_data)
  );

  tsd_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (status)
  );

  tsd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .status_i    (status),
    .head_i      (head),
    .pop_o       (pop),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .out_data_o  (out_data)
  );

  assign out_o.valid     = out_valid;
  assign out_o.kind      = out_data.kind;
  assign out_o.data_byte = out_data.data_byte;
  assign out_o.file_size = out_data.file_size;
  assign out_o.last_byte = out_data.last_byte;

endmodule

[hw/rtl/tsd_checker.sv]
module tsd_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         out_valid_i,
  input  logic         out_ready_i,
  input  logic [1:0]   out_kind_i,
  input  logic [7:0]   out_data_byte_i,
  input  logic [35:0]  out_file_size_i,
  input  logic         out_last_byte_i
);

  logic ended_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ended_q <= 1'b0;
    end else if (out_valid_i && out_ready_i && out_kind_i == tsd_pkg::KIND_END) begin
      ended_q <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_kind_i)
      && $stable(out_data_byte_i) && $stable(out_file_size_i) && $stable(out_last_byte_i))
    else $error("output beat changed while stalled");

  a_marker_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i != tsd_pkg::KIND_PAYLOAD |->
      out_data_byte_i == 8'h00 && !out_last_byte_i)
    else $error("marker beat carries payload bits");

  a_size_only_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i != tsd_pkg::KIND_FILE_START |-> out_file_size_i == '0)
    else $error("file size on a beat other than a file start");

  a_silent_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ended_q |-> !out_valid_i)
    else $error("beat delivered after end of archive");

endmodule

bind tar_stream_deframer tsd_checker u_tsd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_kind_i      (out_o.kind),
  .out_data_byte_i (out_o.data_byte),
  .out_file_size_i (out_o.file_size),
  .out_last_byte_i (out_o.last_byte)
);
